>>> design/airy_pkg.sv
// Shared types and constants for the Airy point-spread evaluator.
// Holds the sequencer state type, fixed-point constants and register map.
// No dependencies.
`default_nettype none

package airy_pkg;

    // Configuration register map.
    localparam int ADDR_W    = 3;
    localparam int REG_SCALE = 0;
    localparam logic [31:0] SCALE_RESET = 32'd16777216;

    // Loop lengths.
    localparam int SERIES_TERMS     = 32;
    localparam int ASYMPTOTIC_TERMS = 8;
    localparam int TAYLOR_ORDER     = 21;
    localparam int K_W              = 7;

    // Fixed-point constants.
    localparam logic [63:0] ONE_Q30         = 64'd1 << 30;
    localparam logic [47:0] SMALL_LIMIT     = 48'd1678;
    localparam logic [47:0] POWER_LIMIT     = 48'd201326592;
    localparam logic [63:0] INV_TWO_PI_Q64  = 64'h28BE60DB9391054A;
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;
    localparam logic [63:0] HALF_PI_Q60     = 64'h1921FB54442D1846;
    localparam logic [31:0] PHASE_OFFSET    = 32'h6000_0000;
    localparam logic [63:0] DIV_ONE_Q62     = 64'd1 << 62;

    // Result region codes.
    localparam logic [1:0] REGION_ZERO  = 2'd0;
    localparam logic [1:0] REGION_SMALL = 2'd1;
    localparam logic [1:0] REGION_POWER = 2'd2;
    localparam logic [1:0] REGION_ASYM  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_X,
        ST_SMALL,
        ST_H,
        ST_PT,
        ST_PD,
        ST_PA,
        ST_W,
        ST_AM1,
        ST_AM2,
        ST_AM3,
        ST_AM4,
        ST_PH,
        ST_PH2,
        ST_A,
        ST_TT,
        ST_TD,
        ST_TA,
        ST_ROT,
        ST_G,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_J,
        ST_MG,
        ST_FINAL,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> design/airy_psf_evaluator.sv
// Airy point-spread evaluator top level: sequencer plus shared multiply,
// divide and square-root units. Depends on airy_pkg.
`default_nettype none

// The block takes one radius word and returns the coherent Airy amplitude
// 2*J1(x)/x (signed Q1.30), the intensity (amplitude squared, unsigned Q1.31)
// and a two-bit code of the formula used. The Bessel argument is
// x = radius * argument_scale in Q24.24, where argument_scale (Q8.24, reset
// value 1.0) is written through the APB port at byte address 0. Radius 0
// gives exactly 1.0; small arguments use a two-term series; arguments below
// 12 use the J1 power series; larger arguments use the Hankel asymptotic
// form. All arithmetic runs on one shared 32x32 multiplier (a 64x64 product
// is built from four partial products), one restoring divider and one
// square-root unit, stepped by a small sequencer. The power-series path
// runs 31 terms; on the asymptotic path the 21 Taylor steps of the phase
// rotation and the coefficient loop (two to eight coefficients) dominate.
// The divider sets most of the run time. A new radius is taken once the
// sequencer is idle again; a finished result may still wait in the output
// register while the next radius is being worked.
module airy_psf_evaluator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [airy_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [15:0]                 s_radius,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [31:0]               m_amplitude,
    output logic      [31:0]                 m_intensity,
    output logic      [1:0]                  m_region
);

    import airy_pkg::*;

    // Round half away from zero while dropping s fraction bits.
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input logic [5:0] s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 6'd1))) >> s;
        return v[63] ? 64'(-m) : m;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Control state.
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [31:0] scale_reg, scale_next;
    logic m_valid_reg, m_valid_next;

    // Datapath registers.
    logic [47:0] x_reg, x_next;
    logic [63:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [127:0] prod_reg, prod_next;
    logic [63:0] dnum_reg, dnum_next, dden_reg, dden_next;
    logic [64:0] drem_reg, drem_next;
    logic [63:0] sq_v_reg, sq_v_next, sq_r_reg, sq_r_next, sq_bit_reg, sq_bit_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [12:0] kk_reg, kk_next, osq_reg, osq_next;
    logic [63:0] h_reg, h_next, term_reg, term_next, w_reg, w_next;
    logic signed [63:0] sum_reg, sum_next, sn_reg, sn_next;
    logic signed [63:0] p_reg, p_next, q_reg, q_next;
    logic [63:0] m_reg, m_next, prev_reg, prev_next;
    logic neg_reg, neg_next;
    logic [1:0] quad_reg, quad_next;
    logic signed [63:0] cv_reg, cv_next, sv_reg, sv_next, acc_reg, acc_next;
    logic pneg_reg, pneg_next, jneg_reg, jneg_next;
    logic signed [63:0] amp_reg, amp_next;
    logic [1:0] region_reg, region_next;
    logic signed [31:0] amp_out_reg, amp_out_next;
    logic [31:0] int_out_reg, int_out_next;
    logic [1:0] reg_out_reg, reg_out_next;

    // Shared-unit datapath.
    logic [63:0] pp;
    logic [1:0] pp_pos;
    logic [127:0] pp_sh;
    logic [64:0] div_trial;
    logic div_ge;
    logic [63:0] sq_sum;
    logic sq_ge;

    // Sequencer intermediates.
    logic [47:0] x_now;
    logic radius_zero;
    logic [12:0] na;
    logic [31:0] turn;
    logic signed [63:0] prod_lo_s;
    logic nm_gt;
    logic neg_n;
    logic signed [63:0] coef;
    logic signed [63:0] ca, sa, s_val, j_val;
    logic [63:0] mag_asym;
    logic signed [63:0] amp_sat;
    logic [63:0] amp_mag;
    logic cfg_wr;
    logic out_load;

    // The 64x64 product is built from four 32x32 partial products, one a cycle.
    assign pp     = ma_reg[{cnt_reg[1], 5'b0} +: 32]
                    * mb_reg[{cnt_reg[0], 5'b0} +: 32];
    assign pp_pos = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
    assign pp_sh  = {64'b0, pp} << {pp_pos, 5'b0};

    assign div_trial = {drem_reg[63:0], dnum_reg[63]};
    assign div_ge    = div_trial >= {1'b0, dden_reg};

    assign sq_sum = sq_r_reg + sq_bit_reg;
    assign sq_ge  = sq_v_reg >= sq_sum;

    // The argument is read straight from the product in the cycle after the
    // first multiply; the radius is still held in the multiplier operand.
    assign x_now       = prod_reg[47:0];
    assign radius_zero = (ma_reg[15:0] == 16'd0);

    assign na        = (k_reg == K_W'(1)) ? 13'd3 : osq_reg - 13'd4;
    assign turn      = prod_reg[87:56] - PHASE_OFFSET;
    assign prod_lo_s = pneg_reg ? 64'(-prod_reg[63:0]) : prod_reg[63:0];
    assign nm_gt     = dnum_reg > prev_reg;
    assign neg_n     = (k_reg >= K_W'(2)) ? ~neg_reg : neg_reg;

    always_comb begin
        coef = neg_n ? 64'(-dnum_reg) : dnum_reg;
        // The sign flips again on odd pair indexes, which is bit 1 of k for
        // both the even and the odd orders.
        if (k_reg[1]) begin
            coef = -coef;
        end
    end

    assign ca       = rnd(sum_reg, 6'd30);
    assign sa       = rnd(sn_reg, 6'd30);
    assign s_val    = rnd(acc_reg - prod_lo_s, 6'd30);
    assign j_val    = rnd(prod_lo_s, 6'd30);
    assign mag_asym = (prod_reg[63:0] + (64'd1 << 36)) >> 37;

    always_comb begin
        amp_sat = amp_reg;
        if (amp_reg > $signed(ONE_Q30)) begin
            amp_sat = ONE_Q30;
        end else if (amp_reg < -$signed(ONE_Q30)) begin
            amp_sat = -$signed(ONE_Q30);
        end
    end
    assign amp_mag = abs64(amp_sat);

    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_SCALE));
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign pready  = 1'b1;
    assign prdata  = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_SCALE)) ? scale_reg : 32'd0;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_amplitude = amp_out_reg;
    assign m_intensity = int_out_reg;
    assign m_region    = reg_out_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (cnt_reg[1:0] == 2'd3) state_next = ret_reg;
            end
            ST_DIV: begin
                if (cnt_reg == 6'd63) state_next = ret_reg;
            end
            ST_SQRT: begin
                if (cnt_reg == 6'd31) state_next = ret_reg;
            end
            ST_X: begin
                if (radius_zero) state_next = ST_FINAL;
                else if (x_now < SMALL_LIMIT) state_next = ST_MUL;
                else if (x_now < POWER_LIMIT) state_next = ST_MUL;
                else state_next = ST_DIV;
            end
            ST_SMALL: state_next = ST_FINAL;
            ST_H:     state_next = ST_PT;
            ST_PT:    state_next = ST_MUL;
            ST_PD:    state_next = ST_DIV;
            ST_PA: begin
                if (k_reg == K_W'(SERIES_TERMS - 1)) state_next = ST_FINAL;
                else state_next = ST_PT;
            end
            ST_W:     state_next = ST_AM1;
            ST_AM1:   state_next = ST_MUL;
            ST_AM2:   state_next = ST_MUL;
            ST_AM3:   state_next = ST_DIV;
            ST_AM4: begin
                if (nm_gt || k_reg == K_W'(ASYMPTOTIC_TERMS)) state_next = ST_PH;
                else state_next = ST_AM1;
            end
            ST_PH:    state_next = ST_MUL;
            ST_PH2:   state_next = ST_MUL;
            ST_A:     state_next = ST_TT;
            ST_TT:    state_next = ST_MUL;
            ST_TD:    state_next = ST_DIV;
            ST_TA: begin
                if (k_reg == K_W'(TAYLOR_ORDER)) state_next = ST_ROT;
                else state_next = ST_TT;
            end
            ST_ROT:   state_next = ST_MUL;
            ST_G:     state_next = ST_SQRT;
            ST_S1:    state_next = ST_MUL;
            ST_S2:    state_next = ST_MUL;
            ST_S3:    state_next = ST_MUL;
            ST_J:     state_next = ST_MUL;
            ST_MG:    state_next = ST_FINAL;
            ST_FINAL: state_next = ST_MUL;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and unit control.
    always_comb begin
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        prod_next   = prod_reg;
        dnum_next   = dnum_reg;
        dden_next   = dden_reg;
        drem_next   = drem_reg;
        sq_v_next   = sq_v_reg;
        sq_r_next   = sq_r_reg;
        sq_bit_next = sq_bit_reg;
        k_next      = k_reg;
        kk_next     = kk_reg;
        osq_next    = osq_reg;
        h_next      = h_reg;
        term_next   = term_reg;
        w_next      = w_reg;
        sum_next    = sum_reg;
        sn_next     = sn_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        m_next      = m_reg;
        prev_next   = prev_reg;
        neg_next    = neg_reg;
        quad_next   = quad_reg;
        cv_next     = cv_reg;
        sv_next     = sv_reg;
        acc_next    = acc_reg;
        pneg_next   = pneg_reg;
        jneg_next   = jneg_reg;
        amp_next    = amp_reg;
        region_next = region_reg;

        unique case (state_reg)
            ST_IDLE: begin
                ma_next   = {48'd0, s_radius};
                mb_next   = {32'd0, scale_reg};
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_X;
            end
            ST_MUL: begin
                prod_next = prod_reg + pp_sh;
                cnt_next  = cnt_reg + 6'd1;
            end
            ST_DIV: begin
                drem_next = div_ge ? div_trial - {1'b0, dden_reg} : div_trial;
                dnum_next = {dnum_reg[62:0], div_ge};
                cnt_next  = cnt_reg + 6'd1;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    sq_v_next = sq_v_reg - sq_sum;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 6'd1;
            end
            ST_X: begin
                x_next    = x_now;
                prod_next = '0;
                cnt_next  = '0;
                if (radius_zero) begin
                    amp_next    = ONE_Q30;
                    region_next = REGION_ZERO;
                end else if (x_now < SMALL_LIMIT || x_now < POWER_LIMIT) begin
                    ma_next  = {16'd0, x_now};
                    mb_next  = {16'd0, x_now};
                    ret_next = (x_now < SMALL_LIMIT) ? ST_SMALL : ST_H;
                end else begin
                    dnum_next = DIV_ONE_Q62;
                    dden_next = {16'd0, x_now};
                    drem_next = '0;
                    ret_next  = ST_W;
                end
            end
            ST_SMALL: begin
                amp_next    = ONE_Q30 - ((prod_reg[63:0] + (64'd1 << 20)) >> 21);
                region_next = REGION_SMALL;
            end
            ST_H: begin
                h_next    = {2'b0, prod_reg[63:2]};
                term_next = 64'd1 << 48;
                sum_next  = 64'd1 << 48;
                k_next    = K_W'(1);
                kk_next   = 13'd2;
            end
            ST_PT: begin
                ma_next   = term_reg;
                mb_next   = h_reg;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_PD;
            end
            ST_PD: begin
                dnum_next = prod_reg[111:48];
                dden_next = {51'd0, kk_reg};
                drem_next = '0;
                cnt_next  = '0;
                ret_next  = ST_PA;
            end
            ST_PA: begin
                term_next = dnum_reg;
                if (k_reg[0]) sum_next = sum_reg - $signed(dnum_reg);
                else sum_next = sum_reg + $signed(dnum_reg);
                if (k_reg == K_W'(SERIES_TERMS - 1)) begin
                    amp_next    = rnd(k_reg[0] ? sum_reg - $signed(dnum_reg)
                                               : sum_reg + $signed(dnum_reg), 6'd18);
                    region_next = REGION_POWER;
                end
                kk_next = kk_reg + {5'd0, k_reg + K_W'(1), 1'b0};
                k_next  = k_reg + K_W'(1);
            end
            ST_W: begin
                w_next    = dnum_reg;
                p_next    = ONE_Q30;
                q_next    = '0;
                m_next    = ONE_Q30;
                prev_next = '1;
                neg_next  = 1'b0;
                k_next    = K_W'(1);
                osq_next  = 13'd1;
            end
            ST_AM1: begin
                ma_next   = m_reg;
                mb_next   = {51'd0, na};
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_AM2;
            end
            ST_AM2: begin
                ma_next   = prod_reg[63:0];
                mb_next   = w_reg;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_AM3;
            end
            ST_AM3: begin
                dnum_next = prod_reg[101:38];
                dden_next = {54'd0, k_reg, 3'b0};
                drem_next = '0;
                cnt_next  = '0;
                ret_next  = ST_AM4;
            end
            ST_AM4: begin
                if (!nm_gt) begin
                    prev_next = dnum_reg;
                    m_next    = dnum_reg;
                    neg_next  = neg_n;
                    if (k_reg[0]) q_next = q_reg + coef;
                    else p_next = p_reg + coef;
                    osq_next = osq_reg + {3'd0, k_reg, 3'b0};
                    k_next   = k_reg + K_W'(1);
                end
            end
            ST_PH: begin
                ma_next   = {16'd0, x_reg};
                mb_next   = INV_TWO_PI_Q64;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_PH2;
            end
            ST_PH2: begin
                quad_next = turn[31:30];
                ma_next   = {34'd0, turn[29:0]};
                mb_next   = HALF_PI_Q60;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_A;
            end
            ST_A: begin
                h_next    = prod_reg[93:30];
                sum_next  = 64'd1 << 60;
                sn_next   = '0;
                term_next = 64'd1 << 60;
                k_next    = K_W'(1);
            end
            ST_TT: begin
                ma_next   = term_reg;
                mb_next   = h_reg;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_TD;
            end
            ST_TD: begin
                dnum_next = prod_reg[123:60];
                dden_next = {{(64 - K_W){1'b0}}, k_reg};
                drem_next = '0;
                cnt_next  = '0;
                ret_next  = ST_TA;
            end
            ST_TA: begin
                term_next = dnum_reg;
                case (k_reg[1:0])
                    2'd0:    sum_next = sum_reg + $signed(dnum_reg);
                    2'd1:    sn_next  = sn_reg + $signed(dnum_reg);
                    2'd2:    sum_next = sum_reg - $signed(dnum_reg);
                    default: sn_next  = sn_reg - $signed(dnum_reg);
                endcase
                k_next = k_reg + K_W'(1);
            end
            ST_ROT: begin
                // Rotate the first-quadrant cosine and sine into place.
                case (quad_reg)
                    2'd0: begin
                        cv_next = ca;
                        sv_next = sa;
                    end
                    2'd1: begin
                        cv_next = -sa;
                        sv_next = ca;
                    end
                    2'd2: begin
                        cv_next = -ca;
                        sv_next = -sa;
                    end
                    default: begin
                        cv_next = sa;
                        sv_next = -ca;
                    end
                endcase
                ma_next   = w_reg;
                mb_next   = TWO_OVER_PI_Q64;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_G;
            end
            ST_G: begin
                sq_v_next   = {prod_reg[105:64], 22'd0};
                sq_r_next   = '0;
                sq_bit_next = 64'd1 << 62;
                cnt_next    = '0;
                ret_next    = ST_S1;
            end
            ST_S1: begin
                ma_next   = abs64(cv_reg);
                mb_next   = abs64(p_reg);
                pneg_next = cv_reg[63] ^ p_reg[63];
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_S2;
            end
            ST_S2: begin
                acc_next  = prod_lo_s;
                ma_next   = abs64(sv_reg);
                mb_next   = abs64(q_reg);
                pneg_next = sv_reg[63] ^ q_reg[63];
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_S3;
            end
            ST_S3: begin
                ma_next   = sq_r_reg;
                mb_next   = abs64(s_val);
                pneg_next = s_val[63];
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_J;
            end
            ST_J: begin
                jneg_next = j_val[63];
                ma_next   = abs64(j_val);
                mb_next   = w_reg;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_MG;
            end
            ST_MG: begin
                amp_next    = jneg_reg ? 64'(-mag_asym) : mag_asym;
                region_next = REGION_ASYM;
            end
            ST_FINAL: begin
                amp_next  = amp_sat;
                ma_next   = amp_mag;
                mb_next   = amp_mag;
                prod_next = '0;
                cnt_next  = '0;
                ret_next  = ST_OUT;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Output register and configuration.
    always_comb begin
        m_valid_next = m_valid_reg;
        amp_out_next = amp_out_reg;
        int_out_next = int_out_reg;
        reg_out_next = reg_out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            amp_out_next = amp_reg[31:0];
            int_out_next = 32'((prod_reg[63:0] + (64'd1 << 28)) >> 29);
            reg_out_next = region_reg;
        end
        scale_next = cfg_wr ? pwdata : scale_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            scale_reg   <= SCALE_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            scale_reg   <= scale_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        prod_reg    <= prod_next;
        dnum_reg    <= dnum_next;
        dden_reg    <= dden_next;
        drem_reg    <= drem_next;
        sq_v_reg    <= sq_v_next;
        sq_r_reg    <= sq_r_next;
        sq_bit_reg  <= sq_bit_next;
        k_reg       <= k_next;
        kk_reg      <= kk_next;
        osq_reg     <= osq_next;
        h_reg       <= h_next;
        term_reg    <= term_next;
        w_reg       <= w_next;
        sum_reg     <= sum_next;
        sn_reg      <= sn_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        m_reg       <= m_next;
        prev_reg    <= prev_next;
        neg_reg     <= neg_next;
        quad_reg    <= quad_next;
        cv_reg      <= cv_next;
        sv_reg      <= sv_next;
        acc_reg     <= acc_next;
        pneg_reg    <= pneg_next;
        jneg_reg    <= jneg_next;
        amp_reg     <= amp_next;
        region_reg  <= region_next;
        amp_out_reg <= amp_out_next;
        int_out_reg <= int_out_next;
        reg_out_reg <= reg_out_next;
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the Airy point-spread evaluator.
// It drives radius words and APB writes of the argument scale, predicts every
// result in place and checks it. Depends on airy_pkg and airy_psf_evaluator.
`timescale 1ns / 100ps

module testbench;
    import airy_pkg::*;

    typedef struct packed {
        logic signed [31:0] amplitude;
        logic [31:0]        intensity;
        logic [1:0]         region;
    } airy_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [15:0]          s_radius = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_amplitude;
    logic [31:0]          m_intensity;
    logic [1:0]           m_region;

    // Radius words waiting to be sent, and predicted results not yet seen.
    logic [15:0]          radius_queue[$];
    airy_result_t         airy_expected[$];

    // Scale as the block holds it, updated when an APB write lands.
    logic [31:0]          scale_now = SCALE_RESET;

    // Idle percentages for the sender and the receiver in the current phase.
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;

    // A long receiver hold-off is requested by bumping this counter.
    int unsigned          hold_request = 0;
    int unsigned          hold_seen = 0;
    int unsigned          hold_left = 0;

    int unsigned          error_count = 0;
    int unsigned          words_checked = 0;
    int unsigned          region_hits[4] = '{0, 0, 0, 0};

    airy_psf_evaluator i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_radius   (s_radius),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_amplitude(m_amplitude),
        .m_intensity(m_intensity),
        .m_region   (m_region)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Fixed-point helpers of the predictor.
    // ------------------------------------------------------------------

    // Full 128-bit product, shifted right and cut to 64 bits.
    function automatic logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> s);
    endfunction

    // Shift right with rounding half away from zero.
    function automatic longint round_away(longint v, int s);
        logic [63:0] mag;
        bit          neg;
        neg = v < 0;
        mag = neg ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2*J1(x)/x by its power series in h = (x/2)^2, Q48 terms, result Q30.
    function automatic longint series_amplitude(logic [63:0] x);
        logic [63:0] h;
        logic [63:0] t;
        longint      acc;
        h = (x * x) >> 2;
        t = 64'd1 << 48;
        acc = longint'(t);
        for (int k = 1; k < SERIES_TERMS; k++) begin
            t = prod_shift(t, h, 48) / 64'(k * (k + 1));
            if (k & 1) acc = acc - longint'(t);
            else acc = acc + longint'(t);
        end
        return round_away(acc, 18);
    endfunction

    // Hankel asymptotic form for large arguments.
    function automatic longint hankel_amplitude(logic [63:0] x);
        logic [63:0]  w, m, prev, nm, na, odd, r, a, t, g, v, mag;
        logic [127:0] ph;
        logic [31:0]  turn;
        logic [1:0]   quad;
        longint       p, q, c, cs, sn, ca, sa, cv, sv, s, j;
        bit           neg;
        w = (64'd1 << 62) / x;
        p = longint'(ONE_Q30);
        q = 0;
        m = ONE_Q30;
        prev = '1;
        neg = 0;
        for (int k = 1; k <= ASYMPTOTIC_TERMS; k++) begin
            odd = 64'(2 * k - 1);
            na = (k == 1) ? 64'd3 : odd * odd - 64'd4;
            nm = prod_shift(m * na, w, 38) / 64'(8 * k);
            if (nm > prev) break;
            prev = nm;
            m = nm;
            if (k >= 2) neg = !neg;
            c = neg ? -longint'(nm) : longint'(nm);
            // Even orders feed P, odd orders feed Q, signed by pair index.
            if ((k & 1) == 0) begin
                if ((k / 2) & 1) c = -c;
                p = p + c;
            end else begin
                if (((k - 1) / 2) & 1) c = -c;
                q = q + c;
            end
        end

        // Phase in turns, minus 3/8 turn, split into quadrant and angle.
        ph = {64'd0, x} * {64'd0, INV_TWO_PI_Q64};
        turn = ph[87:56] - PHASE_OFFSET;
        quad = turn[31:30];
        r = {34'd0, turn[29:0]};
        a = prod_shift(r, HALF_PI_Q60, 30);

        cs = longint'(64'd1 << 60);
        sn = 0;
        t = 64'd1 << 60;
        for (int n = 1; n <= TAYLOR_ORDER; n++) begin
            t = prod_shift(t, a, 60) / 64'(n);
            case (n & 3)
                0: begin
                    cs = cs + longint'(t);
                end
                1: begin
                    sn = sn + longint'(t);
                end
                2: begin
                    cs = cs - longint'(t);
                end
                default: begin
                    sn = sn - longint'(t);
                end
            endcase
        end
        ca = round_away(cs, 30);
        sa = round_away(sn, 30);
        case (quad)
            2'd0: begin
                cv = ca;
                sv = sa;
            end
            2'd1: begin
                cv = -sa;
                sv = ca;
            end
            2'd2: begin
                cv = -ca;
                sv = -sa;
            end
            default: begin
                cv = sa;
                sv = -ca;
            end
        endcase

        g = prod_shift(w, TWO_OVER_PI_Q64, 64);
        v = int_sqrt(g << 22);
        s = round_away(cv * p - sv * q, 30);
        j = round_away(longint'(v) * s, 30);
        mag = (j < 0) ? 64'(-j) : 64'(j);
        mag = (mag * w + (64'd1 << 36)) >> 37;
        return (j < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Expected result for one radius under the given scale.
    function automatic airy_result_t airy_point(logic [15:0] radius, logic [31:0] scale);
        airy_result_t res;
        logic [63:0]  x, mag;
        longint       amp;
        x = {48'd0, radius} * {32'd0, scale};
        if (radius == 0) begin
            amp = longint'(ONE_Q30);
            res.region = REGION_ZERO;
        end else if (x < 64'(SMALL_LIMIT)) begin
            amp = longint'(ONE_Q30) - longint'((x * x + (64'd1 << 20)) >> 21);
            res.region = REGION_SMALL;
        end else if (x < 64'(POWER_LIMIT)) begin
            amp = series_amplitude(x);
            res.region = REGION_POWER;
        end else begin
            amp = hankel_amplitude(x);
            res.region = REGION_ASYM;
        end
        if (amp > longint'(ONE_Q30)) amp = longint'(ONE_Q30);
        if (amp < -longint'(ONE_Q30)) amp = -longint'(ONE_Q30);
        mag = (amp < 0) ? 64'(-amp) : 64'(amp);
        res.amplitude = 32'(amp);
        res.intensity = 32'((mag * mag + (64'd1 << 28)) >> 29);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued radius words, with random idle cycles.
    // Valid is only lowered when no word is waiting or an idle is drawn,
    // and only after the previous word has been taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (radius_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid  <= 1'b1;
                s_radius <= radius_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Every accepted radius word is predicted with the scale in force now.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            airy_expected.insert(airy_expected.size(), airy_point(s_radius, scale_now));
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= 20000;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge aclk) begin
        airy_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (airy_expected.size() == 0) begin
                $display("%0t: result word with nothing expected: amp %0d int %0d reg %0d",
                         $realtime, m_amplitude, m_intensity, m_region);
                error_count <= error_count + 1;
            end else begin
                want = airy_expected.pop_front();
                if (want.amplitude !== m_amplitude || want.intensity !== m_intensity ||
                        want.region !== m_region) begin
                    $display("%0t: mismatch, expected amp/int/reg %0d %0d %0d, got %0d %0d %0d",
                             $realtime, want.amplitude, want.intensity, want.region,
                             m_amplitude, m_intensity, m_region);
                    error_count <= error_count + 1;
                end
                region_hits[want.region] <= region_hits[want.region] + 1;
            end
            words_checked <= words_checked + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases.
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access cycle; the write lands at the
    // edge that closes the access cycle.
    task automatic apb_write_scale(logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(REG_SCALE * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        scale_now <= value;
        @(posedge aclk);
    endtask

    // Waits until every word is sent and every result has come back.
    task automatic drain_all();
        while (radius_queue.size() > 0 || s_valid || airy_expected.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Mostly small radii, so that every region shows up under most scales,
    // and some full-range words so that every radius bit toggles.
    function automatic logic [15:0] pick_radius();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40) return 16'($urandom_range(15));
        if (sel < 60) return 16'($urandom_range(255));
        if (sel < 70) return 16'($urandom_range(4095));
        return 16'($urandom);
    endfunction

    initial begin
        logic [31:0] scale_set[8];
        int unsigned idle_send[4];
        int unsigned idle_recv[4];
        scale_set = '{SCALE_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd100,
                      32'h0040_0000, 32'h0C00_0000, 32'd0};
        idle_send = '{0, 50, 0, 15};
        idle_recv = '{0, 0, 50, 15};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset scale: the zero radius, both sides
        // of the x = 12 boundary, the largest radius and alternating bits.
        radius_queue = '{16'd0, 16'd1, 16'd2, 16'd11, 16'd12, 16'd13, 16'd100,
                         16'hFFFF, 16'hAAAA, 16'h5555};
        drain_all();

        // Zero scale with a nonzero radius still reads as the small series.
        apb_write_scale(32'd0);
        radius_queue = '{16'd5, 16'hFFFF, 16'd0};
        drain_all();

        // Largest scale: huge arguments fade to nothing.
        apb_write_scale(32'hFFFF_FFFF);
        radius_queue = '{16'd1, 16'hFFFF, 16'h8000};
        drain_all();

        // Tiny scale: small-series edge and the power series reached slowly.
        apb_write_scale(32'd1);
        radius_queue = '{16'd1, 16'd1677, 16'd1678, 16'hFFFF};
        drain_all();

        // Random phases, each with its own scale and one of four idle patterns.
        scale_set[7] = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            apb_write_scale(scale_set[ph]);
            send_idle_pct  = idle_send[ph % 4];
            recv_stall_pct = idle_recv[ph % 4];
            for (int i = 0; i < 195; i++)
                radius_queue.insert(radius_queue.size(), pick_radius());
            // Hold the receiver off for a long stretch while words keep coming.
            if (ph == 3)
                hold_request = hold_request + 1;
            drain_all();
        end

        // Finish with the reset value written back explicitly.
        apb_write_scale(SCALE_RESET);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        for (int i = 0; i < 20; i++)
            radius_queue.insert(radius_queue.size(), pick_radius());
        drain_all();
        repeat (3000) @(posedge aclk);

        $display(
            "Checked %0d words: %0d zero, %0d small, %0d power series, %0d asymptotic.",
            words_checked, region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
        $display("Scales swept from 0 through 1 LSB to the maximum, under four idle patterns.");
        if (error_count == 0 && airy_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial begin
        #400_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
design/airy_pkg.sv
design/airy_psf_evaluator.sv
tb/testbench.sv
